/* sv/interpreter_variable_store_unit_defines.svh */
// Assertion macros for the interpreter variable store unit.
`ifndef INTERPRETER_VARIABLE_STORE_UNIT_DEFINES_SVH
`define INTERPRETER_VARIABLE_STORE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define IVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define IVS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define IVS_ASSERT(lbl, prop, msg)
`define IVS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* sv/ivs_pkg.sv */
// Shared types and constants of the interpreter variable store.
package ivs_pkg;
  localparam int ARENA_BYTES  = 1024;
  localparam int ADDR_W       = $clog2(ARENA_BYTES);
  localparam int OFF_W        = 11;
  localparam int VALUE_BYTES  = 4;
  localparam int ENTRY_BYTES  = 2 + VALUE_BYTES;
  localparam int HEADER_BYTES = 4;
  localparam int DEFAULT_LAST = 10;

  localparam logic [2:0] REQ_CREATE = 3'd0;
  localparam logic [2:0] REQ_ARRAY  = 3'd1;
  localparam logic [2:0] REQ_READ   = 3'd2;
  localparam logic [2:0] REQ_CLEAR  = 3'd3;
  localparam logic [2:0] REQ_WRITE  = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REDIM  = 2'd1;
  localparam logic [1:0] ST_SUBSCR = 2'd2;
  localparam logic [1:0] ST_NOMEM  = 2'd3;

  localparam logic CFG_VARS_START  = 1'b0;
  localparam logic CFG_SPACE_LIMIT = 1'b1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] var_name;
    logic [15:0] subscript;
    logic        dim_flag;
    logic [9:0]  write_offset;
    logic [31:0] write_value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] value_offset;
    logic [31:0] read_value;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_ISSUE, S_RD_CAP, S_FS_CHK, S_FS_HIT, S_RV_DONE,
    S_SH_RD, S_SH_WR, S_FILL, S_AW_CHK, S_AW_HIT, S_ARR_NEW, S_DONE
  } state_t;
endpackage

/* sv/interpreter_variable_store_unit.sv */
// Interpreter variable store: byte arena walked by one byte-wide sequencer.
// Latency depends on data: each byte read passes an issue and a capture state,
// each byte written a fill state; a lookup reads each scalar entry or array header
// passed, a scalar insert moves each array byte up, an array create writes each byte.
// One request at a time; the arena RAM port sets the pace. Synchronous reset
// clears control state; arena contents are undefined until written.
`include "interpreter_variable_store_unit_defines.svh"
module interpreter_variable_store_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ivs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ivs_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [10:0]   cfg_data
);
  import ivs_pkg::*;

  state_t state, state_next, rd_ret;

  logic [OFF_W-1:0] vars_start, space_limit, scalar_end, free_start, lim;
  logic [2:0]  req;
  logic [15:0] name, sub;
  logic        dim;
  logic [17:0] a;
  logic [ADDR_W-1:0] rd_base, fill_base;
  logic [2:0]  rcnt, rlen, hdr_len;
  logic [31:0] rdword, hdr;
  logic [OFF_W-1:0] fcnt, flen;
  logic [1:0]  res_st;
  logic [OFF_W-1:0] res_off;
  logic [31:0] res_rval;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic        accept, out_free, name_hit, room_scalar, room_array, sub_err;
  logic [15:0] last, bs;
  logic [18:0] bsz;
  logic [19:0] need;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign lim = (space_limit < OFF_W'(ARENA_BYTES)) ? space_limit : OFF_W'(ARENA_BYTES);
  assign name_hit = (rdword[15:0] == name);
  assign bs = rdword[31:16];
  assign room_scalar = ({1'b0, free_start} + 12'(ENTRY_BYTES)) <= {1'b0, lim};
  assign sub_err = !dim && (sub > 16'(DEFAULT_LAST));
  assign last = dim ? sub : 16'(DEFAULT_LAST);
  assign bsz = {({1'b0, last} + 17'd1), 2'b00};
  assign need = 20'(free_start) + 20'(bsz) + 20'(HEADER_BYTES);
  assign room_array = need <= 20'(lim);

  ivs_ram #(.WIDTH(8), .DEPTH(ARENA_BYTES)) u_arena (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) begin
        unique case (in_data.req_type)
          REQ_CREATE, REQ_READ: state_next = S_FS_CHK;
          REQ_ARRAY:            state_next = S_AW_CHK;
          REQ_WRITE:            state_next = S_FILL;
          default:              state_next = S_DONE;
        endcase
      end
      S_RD_ISSUE: state_next = S_RD_CAP;
      S_RD_CAP:   state_next = (rcnt + 3'd1 == rlen) ? rd_ret : S_RD_ISSUE;
      S_FS_CHK: begin
        if (a < 18'(scalar_end)) state_next = S_RD_ISSUE;
        else if (req == REQ_CREATE && room_scalar) state_next = S_SH_RD;
        else state_next = S_DONE;
      end
      S_FS_HIT: begin
        if (!name_hit) state_next = S_FS_CHK;
        else if (req == REQ_READ) state_next = S_RD_ISSUE;
        else state_next = S_DONE;
      end
      S_RV_DONE: state_next = S_DONE;
      S_SH_RD:   state_next = (a > 18'(scalar_end)) ? S_SH_WR : S_FILL;
      S_SH_WR:   state_next = S_SH_RD;
      S_FILL:    state_next = (fcnt == flen) ? S_DONE : S_FILL;
      S_AW_CHK:  state_next = (a + 18'(HEADER_BYTES) <= 18'(free_start)) ? S_RD_ISSUE
                                                                        : S_ARR_NEW;
      S_AW_HIT:  state_next = name_hit ? S_DONE : S_AW_CHK;
      S_ARR_NEW: state_next = (!sub_err && room_array) ? S_FILL : S_DONE;
      S_DONE:    state_next = out_free ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  // arena port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_base + fcnt[ADDR_W-1:0];
    ram_wdata = (fcnt < OFF_W'(hdr_len)) ? hdr[8*fcnt[1:0] +: 8] : 8'd0;
    ram_raddr = rd_base + ADDR_W'(rcnt);
    unique case (state)
      S_FILL: ram_we = (fcnt != flen);
      S_SH_RD: ram_raddr = a[ADDR_W-1:0] - ADDR_W'(1);
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = a[ADDR_W-1:0] + ADDR_W'(ENTRY_BYTES - 1);
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      vars_start  <= '0;
      space_limit <= OFF_W'(1024);
      scalar_end  <= '0;
      free_start  <= '0;
      out_valid   <= 1'b0;
      rcnt        <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_VARS_START) vars_start <= cfg_data;
        else space_limit <= cfg_data;
      end
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) begin
          req      <= in_data.req_type;
          name     <= in_data.var_name;
          sub      <= in_data.subscript;
          dim      <= in_data.dim_flag;
          res_st   <= ST_OK;
          res_off  <= '0;
          res_rval <= '0;
          fcnt     <= '0;
          unique case (in_data.req_type)
            REQ_CREATE, REQ_READ: a <= 18'(vars_start);
            REQ_ARRAY: a <= 18'(scalar_end);
            REQ_CLEAR: begin
              scalar_end <= vars_start;
              free_start <= vars_start;
            end
            REQ_WRITE: begin
              hdr       <= in_data.write_value;
              hdr_len   <= 3'(VALUE_BYTES);
              flen      <= OFF_W'(VALUE_BYTES);
              fill_base <= in_data.write_offset;
              res_off   <= OFF_W'(in_data.write_offset);
            end
            default: ;
          endcase
        end
        S_RD_CAP: begin
          rdword[8*rcnt[1:0] +: 8] <= ram_rdata;
          rcnt <= (rcnt + 3'd1 == rlen) ? 3'd0 : rcnt + 3'd1;
        end
        S_FS_CHK: begin
          if (a < 18'(scalar_end)) begin
            rd_base <= a[ADDR_W-1:0];
            rlen    <= 3'd2;
            rd_ret  <= S_FS_HIT;
          end else if (req == REQ_CREATE) begin
            if (room_scalar) a <= 18'(free_start);
            else res_st <= ST_NOMEM;
          end
        end
        S_FS_HIT: begin
          if (!name_hit) a <= a + 18'(ENTRY_BYTES);
          else begin
            res_off <= a[OFF_W-1:0] + OFF_W'(2);
            if (req == REQ_READ) begin
              rd_base <= a[ADDR_W-1:0] + ADDR_W'(2);
              rlen    <= 3'(VALUE_BYTES);
              rd_ret  <= S_RV_DONE;
            end
          end
        end
        S_RV_DONE: res_rval <= rdword;
        S_SH_RD: if (!(a > 18'(scalar_end))) begin
          fill_base  <= scalar_end[ADDR_W-1:0];
          hdr        <= {16'd0, name};
          hdr_len    <= 3'd2;
          flen       <= OFF_W'(ENTRY_BYTES);
          res_off    <= scalar_end + OFF_W'(2);
          scalar_end <= scalar_end + OFF_W'(ENTRY_BYTES);
          free_start <= free_start + OFF_W'(ENTRY_BYTES);
        end
        S_SH_WR: a <= a - 18'd1;
        S_FILL: if (fcnt != flen) fcnt <= fcnt + OFF_W'(1);
        S_AW_CHK: if (a + 18'(HEADER_BYTES) <= 18'(free_start)) begin
          rd_base <= a[ADDR_W-1:0];
          rlen    <= 3'd4;
          rd_ret  <= S_AW_HIT;
        end
        S_AW_HIT: begin
          if (!name_hit) a <= a + 18'(HEADER_BYTES) + 18'(bs);
          else if (dim) res_st <= ST_REDIM;
          else if ({sub, 2'b00} >= 18'(bs)) res_st <= ST_SUBSCR;
          else res_off <= 11'(a + 18'(HEADER_BYTES) + {sub, 2'b00});
        end
        S_ARR_NEW: begin
          if (sub_err) res_st <= ST_SUBSCR;
          else if (!room_array) res_st <= ST_NOMEM;
          else begin
            hdr        <= {bsz[15:0], name};
            hdr_len    <= 3'(HEADER_BYTES);
            flen       <= OFF_W'(bsz + 19'(HEADER_BYTES));
            fill_base  <= free_start[ADDR_W-1:0];
            res_off    <= 11'(18'(free_start) + 18'(HEADER_BYTES) + {sub, 2'b00});
            free_start <= need[OFF_W-1:0];
          end
        end
        S_DONE: if (out_free) begin
          out_data.status       <= res_st;
          out_data.value_offset <= res_off;
          out_data.read_value   <= res_rval;
        end
        default: ;
      endcase
    end
  end

  `IVS_ASSERT(a_busy_after_accept, accept |=> (state != S_IDLE), "accept did not start work")
  `IVS_ASSERT(a_fill_bound, (state == S_FILL) |-> (fcnt <= flen), "fill ran past its length")
  `IVS_ASSERT(a_done_loads, (state == S_DONE && out_free) |=> out_valid, "result not loaded")
  `IVS_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !out_valid), "reset not idle")
endmodule

/* sv/ivs_ram.sv */
// Generic single write port, single registered read port RAM.
module ivs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
